@@ hw/rtl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// types, constants and the arctangent table of the cordic sine/cosine block
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int ANGLE_W = 10;
    localparam int TRIG_W  = 14;
    localparam int XY_W    = 16;
    localparam int Z_W     = 12;
    localparam int PROD_W  = XY_W + Z_W;
    localparam int FRAC_BITS = 12;
    localparam int TABLE_LEN = 6;

    localparam logic signed [XY_W-1:0] X_SEED = 16'sd2487;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot;

    function automatic logic signed [Z_W-1:0] atan_step(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 12'sd511;
            1:       v = 12'sd302;
            2:       v = 12'sd159;
            3:       v = 12'sd81;
            4:       v = 12'sd41;
            5:       v = 12'sd20;
            default: v = 12'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/csc_angle_if.sv @@
// ----------------------------------------------------------------------------
// csc_angle_if
// valid/ready channel carrying one input angle item
// ----------------------------------------------------------------------------
interface csc_angle_if;
    logic                          valid;
    logic                          ready;
    logic [csc_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

@@ hw/rtl/csc_trig_if.sv @@
// ----------------------------------------------------------------------------
// csc_trig_if
// valid/ready channel carrying one sine/cosine result item
// ----------------------------------------------------------------------------
interface csc_trig_if;
    logic                  valid;
    logic                  ready;
    csc_pkg::t_trig        sine;
    csc_pkg::t_trig        cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

@@ hw/rtl/csc_rot_stage.sv @@
// ----------------------------------------------------------------------------
// csc_rot_stage
// one registered cordic micro-rotation with its own valid/ready slot
// ----------------------------------------------------------------------------
module csc_rot_stage #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csc_pkg::t_rot   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output csc_pkg::t_rot   o_data
);

    logic                               r_valid;
    csc_pkg::t_rot                      r_data;
    csc_pkg::t_rot                      n_data;
    logic signed [csc_pkg::XY_W-1:0]    xs;
    logic signed [csc_pkg::XY_W-1:0]    ys;

    assign xs = i_data.x >>> IDX;
    assign ys = i_data.y >>> IDX;

    always_comb begin
        if (i_data.z[csc_pkg::Z_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + csc_pkg::atan_step(IDX);
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - csc_pkg::atan_step(IDX);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hw/rtl/cordic_sine_cosine_top.sv @@
// ----------------------------------------------------------------------------
// cordic_sine_cosine_top
// sine and cosine of an angle by a pipelined rotation-mode cordic
// ----------------------------------------------------------------------------
// Takes one angle item per cycle unless the output stalls (4096 units per
// revolution, first octant intended) and returns sine and cosine in signed
// 1.12, with one register stage per micro-rotation, one for the two correction
// multiplies on the residual angle, and one for the final add into the output
// register. Every stage has its own valid bit and stalls only when it is full
// and the stage after it cannot take its item, so bubbles are squeezed out and
// a waiting result does not hold back the input while earlier stages are free.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_top #(
    parameter int STEPS = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csc_angle_if.sink       i_angle,
    csc_trig_if.source      o_trig
);

    logic           s_valid [STEPS+1];
    logic           s_ready [STEPS+1];
    csc_pkg::t_rot  s_data  [STEPS+1];

    assign s_valid[0]  = i_angle.valid;
    assign s_data[0].x = csc_pkg::X_SEED;
    assign s_data[0].y = '0;
    assign s_data[0].z = $signed({{(csc_pkg::Z_W-csc_pkg::ANGLE_W){1'b0}}, i_angle.angle});
    assign i_angle.ready = s_ready[0];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_rot
            csc_rot_stage #(.IDX(k)) u_rot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (s_valid[k]),
                .o_ready (s_ready[k]),
                .i_data  (s_data[k]),
                .o_valid (s_valid[k+1]),
                .i_ready (s_ready[k+1]),
                .o_data  (s_data[k+1])
            );
        end
    endgenerate

    // correction multiply stage
    logic                                 r_m_valid;
    logic                                 m_ready;
    logic signed [csc_pkg::PROD_W-1:0]    r_m_zy;
    logic signed [csc_pkg::PROD_W-1:0]    r_m_zx;
    logic signed [csc_pkg::XY_W-1:0]      r_m_x;
    logic signed [csc_pkg::XY_W-1:0]      r_m_y;
    logic signed [csc_pkg::PROD_W-1:0]    n_m_zy;
    logic signed [csc_pkg::PROD_W-1:0]    n_m_zx;

    // output stage
    logic                                 r_o_valid;
    logic                                 o_ready_int;
    csc_pkg::t_trig                       r_o_sine;
    csc_pkg::t_trig                       r_o_cosine;
    logic signed [csc_pkg::XY_W-1:0]      n_sine;
    logic signed [csc_pkg::XY_W-1:0]      n_cosine;

    assign o_ready_int     = !r_o_valid || o_trig.ready;
    assign m_ready         = !r_m_valid || o_ready_int;
    assign s_ready[STEPS]  = m_ready;

    assign n_m_zy = csc_pkg::PROD_W'(s_data[STEPS].z) * csc_pkg::PROD_W'(s_data[STEPS].y);
    assign n_m_zx = csc_pkg::PROD_W'(s_data[STEPS].z) * csc_pkg::PROD_W'(s_data[STEPS].x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_ready) begin
            r_m_valid <= s_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && s_valid[STEPS]) begin
            r_m_zy <= n_m_zy;
            r_m_zx <= n_m_zx;
            r_m_x  <= s_data[STEPS].x;
            r_m_y  <= s_data[STEPS].y;
        end
    end

    // arithmetic shift by the fraction width, kept to the vector width
    assign n_cosine = r_m_x - r_m_zy[csc_pkg::FRAC_BITS +: csc_pkg::XY_W];
    assign n_sine   = r_m_y + r_m_zx[csc_pkg::FRAC_BITS +: csc_pkg::XY_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_ready_int) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready_int && r_m_valid) begin
            r_o_sine   <= n_sine[csc_pkg::TRIG_W-1:0];
            r_o_cosine <= n_cosine[csc_pkg::TRIG_W-1:0];
        end
    end

    assign o_trig.valid  = r_o_valid;
    assign o_trig.sine   = r_o_sine;
    assign o_trig.cosine = r_o_cosine;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_o_valid && !r_m_valid))
        else $error("pipeline not empty after reset");

    a_mult_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !o_ready_int) |=> (r_m_valid && $stable(r_m_zy) && $stable(r_m_zx)))
        else $error("multiply stage lost or changed a stalled item");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_trig.ready && r_m_valid) |=> (r_o_valid && r_m_valid))
        else $error("stalled output dropped an item");

endmodule
